// ----- design/spq_pkg.sv -----
// shared types, codes and sizes for the sorted priority queue
package spq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OCC_W = 5;
  localparam int unsigned PRI_W = 8;
  localparam int unsigned TAG_W = 8;
  localparam int unsigned STS_W = 2;

  // operation codes of the func field
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // result status codes
  localparam logic [STS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STS_W-1:0] STATUS_EMPTY = 2'd2;

  // operation the controller orders from the datapath
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_REFUSE_FULL,
    OP_REFUSE_EMPTY
  } spq_op_e;

  typedef struct packed {
    logic             func;
    logic [PRI_W-1:0] priority_req;
    logic [TAG_W-1:0] item_tag;
  } spq_in_t;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [PRI_W-1:0] head_priority;
    logic [TAG_W-1:0] head_tag;
    logic [OCC_W-1:0] occupancy;
  } spq_out_t;

  typedef struct packed {
    logic    load;
    spq_op_e op;
  } spq_cmd_t;

  typedef struct packed {
    logic req_insert;
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

// ----- design/spq_ctrl.sv -----
// controller state machine sequencing one item at a time
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  spq_pkg::spq_stat_t stat_i,
  output spq_pkg::spq_cmd_t  cmd_o
);
  import spq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.op    = OP_NONE;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.req_insert) begin
          cmd_o.op = stat_i.full ? OP_REFUSE_FULL : OP_INSERT;
        end else begin
          cmd_o.op = stat_i.empty ? OP_REFUSE_EMPTY : OP_REMOVE;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/spq_datapath.sv -----
// slot row with per-slot compare, entry count and result register
module spq_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spq_pkg::spq_in_t   in_data_i,
  input  spq_pkg::spq_cmd_t  cmd_i,
  output spq_pkg::spq_stat_t stat_o,
  output spq_pkg::spq_out_t  out_data_o
);
  import spq_pkg::*;

  spq_in_t          req_q;
  spq_out_t         res_q, res_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PRI_W-1:0] slot_pri_q [DEPTH];
  logic [PRI_W-1:0] slot_pri_d [DEPTH];
  logic [TAG_W-1:0] slot_tag_q [DEPTH];
  logic [TAG_W-1:0] slot_tag_d [DEPTH];
  logic [DEPTH-1:0] keep;

  // status towards the controller
  assign stat_o.req_insert = (req_q.func == FUNC_INSERT);
  assign stat_o.full       = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty      = (count_q == '0);
  assign out_data_o        = res_q;

  // every held slot at or above the new priority stays in place
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      keep[k] = (CNT_W'(k) < count_q) && (slot_pri_q[k] >= req_q.priority_req);
    end
  end

  // slot row update, count and result
  always_comb begin
    slot_pri_d = slot_pri_q;
    slot_tag_d = slot_tag_q;
    count_d    = count_q;
    res_d      = res_q;
    case (cmd_i.op)
      OP_INSERT: begin
        // head slot takes the new entry unless it stays
        if (!keep[0]) begin
          slot_pri_d[0] = req_q.priority_req;
          slot_tag_d[0] = req_q.item_tag;
        end
        for (int k = 1; k < DEPTH; k++) begin
          if (!keep[k]) begin
            if (keep[k-1]) begin
              slot_pri_d[k] = req_q.priority_req;
              slot_tag_d[k] = req_q.item_tag;
            end else begin
              slot_pri_d[k] = slot_pri_q[k-1];
              slot_tag_d[k] = slot_tag_q[k-1];
            end
          end
        end
        count_d = count_q + CNT_W'(1);
        res_d   = '{STATUS_OK, '0, '0, OCC_W'(count_q + CNT_W'(1))};
      end
      OP_REMOVE: begin
        for (int k = 0; k < DEPTH - 1; k++) begin
          slot_pri_d[k] = slot_pri_q[k+1];
          slot_tag_d[k] = slot_tag_q[k+1];
        end
        count_d = count_q - CNT_W'(1);
        res_d   = '{STATUS_OK, slot_pri_q[0], slot_tag_q[0],
                    OCC_W'(count_q - CNT_W'(1))};
      end
      OP_REFUSE_FULL: begin
        res_d = '{STATUS_FULL, '0, '0, OCC_W'(count_q)};
      end
      OP_REFUSE_EMPTY: begin
        res_d = '{STATUS_EMPTY, '0, '0, OCC_W'(count_q)};
      end
      default: begin
      end
    endcase
  end

  // entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // request, slots and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    slot_pri_q <= slot_pri_d;
    slot_tag_q <= slot_tag_d;
    res_q      <= res_d;
  end

endmodule

// ----- design/sorted_priority_queue.sv -----
// sorted priority queue: item in, one result out after a compare-and-shift pass
// the result becomes valid once the execute state has registered it, and holds until taken
// one item held at a time: the controller steps through its accept, execute and respond
//   states and takes no new item until the result has been taken
// reset: clears the entry count and the controller; slot contents are not cleared
module sorted_priority_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spq_pkg::spq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spq_pkg::spq_out_t out_data_o
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  // sequencing
  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // slot row and result
  spq_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_data_o(out_data_o)
  );

endmodule

// ----- design/spq_checker.sv -----
// port-level checks for the sorted priority queue, bound to the top level
module spq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input spq_pkg::spq_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input spq_pkg::spq_out_t out_data_o
);
  import spq_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one item in flight: nothing accepted while a result waits, none right after
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !out_valid_o ##1 !in_ready_o)
    else $error("second item taken while one is in flight");

  // full refusal only at full occupancy, empty refusal only at zero
  a_refuse_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.status != STATUS_FULL || out_data_o.occupancy == OCC_W'(DEPTH)) &&
      (out_data_o.status != STATUS_EMPTY || out_data_o.occupancy == '0))
    else $error("refusal status disagrees with occupancy");

  // head fields are zero on a refused item
  a_zero_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STATUS_OK |->
      out_data_o.head_priority == '0 && out_data_o.head_tag == '0)
    else $error("head fields set on a refused item");

  // status code in range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status == STATUS_OK ||
      out_data_o.status == STATUS_FULL || out_data_o.status == STATUS_EMPTY)
    else $error("unknown status code");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

// ----- test/tb_top.sv -----
// testbench for the sorted priority queue: directed table, then random items checked
`timescale 1ns / 1ps

module tb_top;
  import spq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned TABLE_ROWS = 22;
  localparam int unsigned REPORT_MAX = 10;

  // receiver stall patterns
  localparam int unsigned RX_ALWAYS = 0;
  localparam int unsigned RX_MOSTLY = 1;
  localparam int unsigned RX_SELDOM = 2;
  localparam int unsigned RX_PULSE  = 3;

  typedef struct packed {
    spq_in_t  item;
    logic     known;
    spq_out_t want;
  } stim_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  spq_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  spq_out_t out_data_o;

  // expectation carried along with the item on offer
  logic     pend_known = 1'b0;
  spq_out_t pend_want = '0;

  // model of the queue contents, slot 0 is the head
  logic [PRI_W-1:0] held_pri [DEPTH];
  logic [TAG_W-1:0] held_tag [DEPTH];
  int unsigned      held_cnt = 0;

  spq_out_t    pending_results [$];
  stim_row_t   dir_rows [TABLE_ROWS];
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = RX_ALWAYS;

  sorted_priority_queue uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // apply one item to the model queue and return its result
  function automatic spq_out_t queue_apply(spq_in_t it);
    spq_out_t    res;
    int unsigned pos;
    int unsigned k;
    res = '0;
    if (it.func == FUNC_INSERT) begin
      if (held_cnt >= DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        // new entry goes behind every entry of equal or higher priority
        pos = 0;
        while (pos < held_cnt && held_pri[pos] >= it.priority_req) pos++;
        for (k = held_cnt; k > pos; k--) begin
          held_pri[k] = held_pri[k-1];
          held_tag[k] = held_tag[k-1];
        end
        held_pri[pos] = it.priority_req;
        held_tag[pos] = it.item_tag;
        held_cnt++;
      end
    end else begin
      if (held_cnt == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.head_priority = held_pri[0];
        res.head_tag = held_tag[0];
        for (k = 1; k < held_cnt; k++) begin
          held_pri[k-1] = held_pri[k];
          held_tag[k-1] = held_tag[k];
        end
        held_cnt--;
      end
    end
    res.status = (res.status == '0) ? STATUS_OK : res.status;
    res.occupancy = OCC_W'(held_cnt);
    return res;
  endfunction

  task automatic note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
  endtask

  // offer one item in bursts with random gaps, return at the edge it is taken
  task automatic send_item(spq_in_t it, logic known, spq_out_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    in_data_i  <= it;
    pend_known <= known;
    pend_want  <= want;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // receiver stalls on patterns that are redrawn at random, each kept for a random run
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(RX_ALWAYS, RX_PULSE);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    case (stall_mode)
      RX_ALWAYS: out_ready_i <= 1'b1;
      RX_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
      RX_SELDOM: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= (stall_left % 5 == 0);
    endcase
  end

  // predict on every accepted item, check every accepted result
  always @(posedge clk_i) begin
    spq_out_t predicted;
    spq_out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predicted = queue_apply(in_data_i);
        pending_results.push_back(pend_known ? pend_want : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          note_failure($sformatf("unexpected result %p", out_data_o));
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.status !== want.status ||
              out_data_o.head_priority !== want.head_priority ||
              out_data_o.head_tag !== want.head_tag ||
              out_data_o.occupancy !== want.occupancy) begin
            note_failure($sformatf(
              {"mismatch: exp sts=%0d pri=%0d tag=%0d occ=%0d,",
               " got sts=%0d pri=%0d tag=%0d occ=%0d"},
              want.status, want.head_priority, want.head_tag, want.occupancy,
              out_data_o.status, out_data_o.head_priority, out_data_o.head_tag,
              out_data_o.occupancy));
          end
        end
      end
    end
  end

  // run-time guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("sorted_priority_queue verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    spq_in_t     it;
    int unsigned ins_pct;
    int unsigned n;

    // directed table: empty remove, ties, extremes, fill to full, drain a little
    dir_rows[0]  = '{item: '{FUNC_REMOVE, 8'd0, 8'd0}, known: 1'b1,
                     want: '{STATUS_EMPTY, 8'd0, 8'd0, 5'd0}};
    dir_rows[1]  = '{item: '{FUNC_INSERT, 8'd0, 8'h00}, known: 1'b1,
                     want: '{STATUS_OK, 8'd0, 8'd0, 5'd1}};
    dir_rows[2]  = '{item: '{FUNC_INSERT, 8'd255, 8'hFF}, known: 1'b0, want: '0};
    dir_rows[3]  = '{item: '{FUNC_INSERT, 8'd255, 8'h5A}, known: 1'b0, want: '0};
    dir_rows[4]  = '{item: '{FUNC_INSERT, 8'd128, 8'h01}, known: 1'b0, want: '0};
    dir_rows[5]  = '{item: '{FUNC_INSERT, 8'd0, 8'h80}, known: 1'b0, want: '0};
    dir_rows[6]  = '{item: '{FUNC_INSERT, 8'd1, 8'h02}, known: 1'b0, want: '0};
    dir_rows[7]  = '{item: '{FUNC_INSERT, 8'd254, 8'h03}, known: 1'b0, want: '0};
    dir_rows[8]  = '{item: '{FUNC_INSERT, 8'd128, 8'h04}, known: 1'b0, want: '0};
    dir_rows[9]  = '{item: '{FUNC_INSERT, 8'd127, 8'hA5}, known: 1'b0, want: '0};
    dir_rows[10] = '{item: '{FUNC_INSERT, 8'd64, 8'h10}, known: 1'b0, want: '0};
    dir_rows[11] = '{item: '{FUNC_INSERT, 8'd64, 8'h11}, known: 1'b0, want: '0};
    dir_rows[12] = '{item: '{FUNC_INSERT, 8'd2, 8'h20}, known: 1'b0, want: '0};
    dir_rows[13] = '{item: '{FUNC_INSERT, 8'd200, 8'hC3}, known: 1'b0, want: '0};
    dir_rows[14] = '{item: '{FUNC_INSERT, 8'd100, 8'h3C}, known: 1'b0, want: '0};
    dir_rows[15] = '{item: '{FUNC_INSERT, 8'd50, 8'h55}, known: 1'b0, want: '0};
    dir_rows[16] = '{item: '{FUNC_INSERT, 8'd255, 8'hAA}, known: 1'b1,
                     want: '{STATUS_OK, 8'd0, 8'd0, 5'd16}};
    dir_rows[17] = '{item: '{FUNC_INSERT, 8'd77, 8'h77}, known: 1'b1,
                     want: '{STATUS_FULL, 8'd0, 8'd0, 5'd16}};
    dir_rows[18] = '{item: '{FUNC_REMOVE, 8'd9, 8'h99}, known: 1'b1,
                     want: '{STATUS_OK, 8'd255, 8'hFF, 5'd15}};
    dir_rows[19] = '{item: '{FUNC_REMOVE, 8'd0, 8'h00}, known: 1'b0, want: '0};
    dir_rows[20] = '{item: '{FUNC_INSERT, 8'd255, 8'h01}, known: 1'b0, want: '0};
    dir_rows[21] = '{item: '{FUNC_REMOVE, 8'd255, 8'hFF}, known: 1'b0, want: '0};

    // reset
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < TABLE_ROWS; n++)
      send_item(dir_rows[n].item, dir_rows[n].known, dir_rows[n].want);

    // random items, insert share swept so the queue runs empty and full
    ins_pct = 50;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 48 == 0) begin
        case ($urandom_range(0, 3))
          0: ins_pct = 15;
          1: ins_pct = 85;
          2: ins_pct = 50;
          default: ins_pct = $urandom_range(5, 95);
        endcase
      end
      it.func = ($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE;
      // narrow priority ranges give plenty of ties
      case ($urandom_range(0, 3))
        0: it.priority_req = 8'($urandom_range(0, 255));
        1: it.priority_req = 8'($urandom_range(0, 3));
        2: it.priority_req = 8'($urandom_range(252, 255));
        default: it.priority_req = 8'($urandom_range(0, 7) * 32);
      endcase
      it.item_tag = 8'($urandom_range(0, 255));
      send_item(it, 1'b0, '0);
    end

    // drain
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("sorted_priority_queue verification clean");
    end else begin
      $display("sorted_priority_queue verification failed");
    end
    $finish;
  end

endmodule
